>>> design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, types and the hash fold for the linear-probe hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

    localparam int SLOTS    = 256;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int KEY_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int CNT_W    = 8;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;
    localparam logic [CNT_W-1:0] HALF_SLOTS = CNT_W'(SLOTS / 2);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_HOME,
        S_PROBE,
        S_CHK,
        S_RM_CHK,
        S_RM_RD,
        S_RM_CMP,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    // xor-fold of the multiplied key, masked to the slot index
    function automatic logic [IDX_W-1:0] hash_fold(input logic [31:0] p);
        logic [31:0] f;
        f = p ^ (p >> 16);
        return f[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_in_if / lpht_out_if
// Valid/ready channels for commands and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpht_in_if
    import lpht_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [KEY_W-1:0]    stream_key;
    logic [HANDLE_W-1:0] handle_in;

    modport source (output valid, cmd, stream_key, handle_in, input ready);
    modport sink   (input valid, cmd, stream_key, handle_in, output ready);
endinterface

interface lpht_out_if
    import lpht_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, status, handle_out, entry_count, input ready);
    modport sink   (input valid, status, handle_out, entry_count, output ready);
endinterface

`default_nettype wire

>>> design/linear_probe_hash_table.sv
// Sequence, accept to response valid: clear and a refused insert go straight to the response;
//   others hash the key, load the home slot, then probe each slot until a match or an empty one.
//   Erase then reads, rehashes and compares each occupied slot behind the hit.
// Flow: one transaction at a time, next accept the cycle after the response loads;
//   the length of the probe walk sets the rate.
// Reset: synchronous, active low; occupancy bits and entry count clear at once.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed key -> handle map, linear probing, backward-shift erase.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    lpht_in_if.sink      i_req,
    lpht_out_if.source   o_rsp
);

    // Entry memory: key and handle per slot, one write and one registered read.
    t_entry mem [SLOTS];

    // Occupancy bits live in flops so reset and clear empty the table at once.
    logic [SLOTS-1:0] r_occ;

    t_state r_state, n_state;

    t_cmd                r_cmd,  n_cmd;
    logic [KEY_W-1:0]    r_key,  n_key;
    logic [HANDLE_W-1:0] r_hin,  n_hin;
    logic [IDX_W-1:0]    r_ptr,  n_ptr;    // probe position / erase scan cursor
    logic [IDX_W-1:0]    r_hole, n_hole;   // erase: slot waiting to be filled
    logic [31:0]         r_prod, n_prod;   // registered hash product
    t_entry              r_rd;             // registered read of mem[r_ptr]
    logic [CNT_W-1:0]    r_cnt,  n_cnt;
    t_status             r_status, n_status;
    logic [HANDLE_W-1:0] r_hout, n_hout;

    // Response register
    logic                r_ov, n_ov;
    t_status             r_o_status, n_o_status;
    logic [HANDLE_W-1:0] r_o_hout, n_o_hout;
    logic [CNT_W-1:0]    r_o_cnt, n_o_cnt;

    // Memory and occupancy write controls
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_entry           mem_wd;
    logic             occ_set, occ_clr, occ_clr_all;
    logic [IDX_W-1:0] occ_idx;

    logic             acc;
    logic             rsp_free;
    logic [31:0]      mul_a;
    logic [31:0]      mul_p;
    logic [IDX_W-1:0] home;
    logic [IDX_W-1:0] d_hole, d_cur;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign rsp_free    = !r_ov || o_rsp.ready;

    // Shared hash multiplier: command key in HASH, scanned entry key in RM_RD
    assign mul_a  = (r_state == S_RM_RD) ? {1'b0, r_rd.key} : {1'b0, r_key};
    assign mul_p  = mul_a * HASH_MUL;
    assign home   = hash_fold(r_prod);
    assign d_hole = r_hole - home;
    assign d_cur  = r_ptr - home;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (t_cmd'(i_req.cmd) == CMD_CLEAR) begin
                        n_state = S_RESP;
                    end else if (t_cmd'(i_req.cmd) == CMD_INSERT && r_cnt >= HALF_SLOTS) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH:  n_state = S_HOME;
            S_HOME:  n_state = S_PROBE;
            S_PROBE: n_state = r_occ[r_ptr] ? S_CHK : S_RESP;
            S_CHK: begin
                if (r_rd.key == r_key) begin
                    n_state = (r_cmd == CMD_ERASE) ? S_RM_CHK : S_RESP;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_RM_CHK: n_state = r_occ[r_ptr] ? S_RM_RD : S_RESP;
            S_RM_RD:  n_state = S_RM_CMP;
            S_RM_CMP: n_state = S_RM_CHK;
            S_RESP:   n_state = rsp_free ? S_IDLE : S_RESP;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_hin      = r_hin;
        n_ptr      = r_ptr;
        n_hole     = r_hole;
        n_prod     = r_prod;
        n_cnt      = r_cnt;
        n_status   = r_status;
        n_hout     = r_hout;
        n_ov       = r_ov && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_hout   = r_o_hout;
        n_o_cnt    = r_o_cnt;
        mem_we      = 1'b0;
        mem_wa      = r_ptr;
        mem_wd      = '{key: r_key, handle: r_hin};
        occ_set     = 1'b0;
        occ_clr     = 1'b0;
        occ_clr_all = 1'b0;
        occ_idx     = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cmd    = t_cmd'(i_req.cmd);
                    n_key    = i_req.stream_key;
                    n_hin    = i_req.handle_in;
                    n_hout   = '0;
                    n_status = ST_OK;
                    if (t_cmd'(i_req.cmd) == CMD_CLEAR) begin
                        occ_clr_all = 1'b1;
                        n_cnt       = '0;
                    end else if (t_cmd'(i_req.cmd) == CMD_INSERT && r_cnt >= HALF_SLOTS) begin
                        n_status = ST_FULL;
                    end
                end
            end
            S_HASH: n_prod = mul_p;
            S_HOME: n_ptr  = home;
            S_PROBE: begin
                // empty slot ends the chain
                if (!r_occ[r_ptr]) begin
                    if (r_cmd == CMD_INSERT) begin
                        mem_we  = 1'b1;
                        occ_set = 1'b1;
                        n_cnt   = r_cnt + CNT_W'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_CHK: begin
                if (r_rd.key == r_key) begin
                    case (r_cmd)
                        CMD_INSERT: n_status = ST_DUPLICATE;
                        CMD_ERASE: begin
                            n_hout = r_rd.handle;
                            n_hole = r_ptr;
                            n_ptr  = r_ptr + IDX_W'(1);
                        end
                        default: n_hout = r_rd.handle;
                    endcase
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_RM_CHK: begin
                if (!r_occ[r_ptr]) begin
                    occ_clr = 1'b1;
                    occ_idx = r_hole;
                    n_cnt   = r_cnt - CNT_W'(1);
                end
            end
            S_RM_RD: n_prod = mul_p;
            S_RM_CMP: begin
                // shift back when the hole is closer to the entry's home
                if (d_hole < d_cur) begin
                    mem_we = 1'b1;
                    mem_wa = r_hole;
                    mem_wd = r_rd;
                    n_hole = r_ptr;
                end
                n_ptr = r_ptr + IDX_W'(1);
            end
            S_RESP: begin
                if (rsp_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_hout   = r_hout;
                    n_o_cnt    = r_cnt;
                end
            end
            default: ;
        endcase
    end

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[r_ptr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            if (occ_clr_all) begin
                r_occ <= '0;
            end else if (occ_set) begin
                r_occ[occ_idx] <= 1'b1;
            end else if (occ_clr) begin
                r_occ[occ_idx] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_hin      <= n_hin;
        r_ptr      <= n_ptr;
        r_hole     <= n_hole;
        r_prod     <= n_prod;
        r_status   <= n_status;
        r_hout     <= n_hout;
        r_o_status <= n_o_status;
        r_o_hout   <= n_o_hout;
        r_o_cnt    <= n_o_cnt;
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.handle_out  = r_o_hout;
    assign o_rsp.entry_count = r_o_cnt;

endmodule

`default_nettype wire

>>> design/lpht_chk.sv
// ----------------------------------------------------------------------------
// lpht_chk
// Port-level checks for the linear-probe hash table.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_chk
    import lpht_pkg::*;
(
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [1:0]          i_status,
    input wire [HANDLE_W-1:0] i_handle_out,
    input wire [CNT_W-1:0]    i_entry_count
);

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
        && $stable(i_handle_out) && $stable(i_entry_count))
        else $error("stalled response changed");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_entry_count <= HALF_SLOTS)
        else $error("entry count above half the slots");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> i_handle_out == '0)
        else $error("nonzero handle on failed command");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_handle_out  (o_rsp.handle_out),
    .i_entry_count (o_rsp.entry_count)
);

`default_nettype wire

>>> verif/lpht_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the command and response channels, keeps a shadow table and
// compares every response with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_checker
    import lpht_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    lpht_in_if.sink   i_req,
    lpht_out_if.sink  i_rsp,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    count;
    } t_answer;

    logic [KEY_W-1:0]    shadow_key    [SLOTS];
    logic [HANDLE_W-1:0] shadow_handle [SLOTS];
    logic                shadow_used   [SLOTS];
    int                  shadow_count;
    t_answer             answer_q[$];

    function automatic int home_of(logic [KEY_W-1:0] key);
        logic [31:0] h;
        h = {1'b0, key} * HASH_MUL;
        h = h ^ (h >> 16);
        return int'(h) & (SLOTS - 1);
    endfunction

    // Returns slot index or -1 on miss
    function automatic int locate_key(logic [KEY_W-1:0] key);
        int idx;
        idx = home_of(key);
        for (int n = 0; n < SLOTS; n++) begin
            if (!shadow_used[idx]) return -1;
            if (shadow_key[idx] == key) return idx;
            idx = (idx + 1) & (SLOTS - 1);
        end
        return -1;
    endfunction

    // Backward-shift deletion
    function automatic void shift_out(int slot);
        int hole, cur, hm;
        hole = slot;
        cur  = (hole + 1) & (SLOTS - 1);
        for (int n = 0; n < SLOTS && shadow_used[cur]; n++) begin
            hm = home_of(shadow_key[cur]);
            if (((hole - hm) & (SLOTS - 1)) < ((cur - hm) & (SLOTS - 1))) begin
                shadow_key[hole]    = shadow_key[cur];
                shadow_handle[hole] = shadow_handle[cur];
                shadow_used[hole]   = 1'b1;
                hole = cur;
            end
            cur = (cur + 1) & (SLOTS - 1);
        end
        shadow_used[hole] = 1'b0;
        if (shadow_count > 0) shadow_count--;
    endfunction

    function automatic t_answer apply_command(t_cmd cmd, logic [KEY_W-1:0] key,
                                              logic [HANDLE_W-1:0] hin);
        t_answer a;
        int idx;
        a = '{ST_OK, '0, '0};
        case (cmd)
            CMD_INSERT: begin
                if ((shadow_count + 1) * 2 > SLOTS) begin
                    a.status = ST_FULL;
                end else begin
                    idx = home_of(key);
                    a.status = ST_FULL;
                    for (int n = 0; n < SLOTS; n++) begin
                        if (!shadow_used[idx]) begin
                            shadow_key[idx]    = key;
                            shadow_handle[idx] = hin;
                            shadow_used[idx]   = 1'b1;
                            shadow_count++;
                            a.status = ST_OK;
                            break;
                        end
                        if (shadow_key[idx] == key) begin
                            a.status = ST_DUPLICATE;
                            break;
                        end
                        idx = (idx + 1) & (SLOTS - 1);
                    end
                end
            end
            CMD_FIND, CMD_ERASE: begin
                idx = locate_key(key);
                if (idx < 0) begin
                    a.status = ST_NOT_FOUND;
                end else begin
                    a.handle = shadow_handle[idx];
                    if (cmd == CMD_ERASE) shift_out(idx);
                end
            end
            default: begin
                for (int s = 0; s < SLOTS; s++) shadow_used[s] = 1'b0;
                shadow_count = 0;
            end
        endcase
        a.count = CNT_W'(shadow_count);
        return a;
    endfunction

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) shadow_used[s] = 1'b0;
            shadow_count = 0;
            answer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_req.valid && i_req.ready)
                answer_q.push_back(apply_command(t_cmd'(i_req.cmd), i_req.stream_key,
                                                 i_req.handle_in));
            if (i_rsp.valid && i_rsp.ready) begin
                if (answer_q.size() == 0) begin
                    $error("response with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (i_rsp.status != want.status || i_rsp.handle_out != want.handle
                        || i_rsp.entry_count != want.count) begin
                        if (i_rsp.status != want.status)
                            $error("status: expected %0d, got %0d", want.status,
                                   i_rsp.status);
                        if (i_rsp.handle_out != want.handle)
                            $error("handle_out: expected %h, got %h", want.handle,
                                   i_rsp.handle_out);
                        if (i_rsp.entry_count != want.count)
                            $error("entry_count: expected %0d, got %0d", want.count,
                                   i_rsp.entry_count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_linear_probe_hash_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Directed and random insert/find/erase/clear traffic with bursty commands
// and a stalling response side; a checker module predicts every response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, cycle_count;

    // Keys already used, so random traffic hits present entries often
    logic [KEY_W-1:0] key_pool[$];

    lpht_in_if  req_if ();
    lpht_out_if rsp_if ();

    linear_probe_hash_table uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    lpht_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if.sink),
        .i_rsp       (rsp_if.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver stalls in its own pattern: runs of ready, runs of stall, and
    // long stretches of always-ready.
    initial begin
        int run;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                run = $urandom_range(1, 12);
                case ($urandom_range(0, 3))
                    0: rsp_if.ready <= 1'b0;
                    1: begin rsp_if.ready <= 1'b1; run = run * 8; end
                    default: rsp_if.ready <= 1'b1;
                endcase
            end else begin
                run--;
            end
        end
    end

    // One command transaction; valid stays high on return until idle_gap or the caller drops it
    task automatic send_cmd(t_cmd cmd, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] hin);
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.stream_key <= key;
        req_if.handle_in  <= hin;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            req_if.valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = KEY_W'($urandom());
        if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 1) ? '0 : '1;
        key_pool.push_back(k);
        if (key_pool.size() > 300) key_pool.delete(0);
        return k;
    endfunction

    initial begin
        int burst;
        t_cmd c;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_INSERT;
        req_if.stream_key = '0;
        req_if.handle_in  = '0;
        cycle_count       = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every command, duplicate, misses, clear
        send_cmd(CMD_FIND,   '0, '0);                  // miss on empty table
        send_cmd(CMD_ERASE,  '1, '0);                  // erase miss
        send_cmd(CMD_INSERT, '0, '1);
        send_cmd(CMD_INSERT, '1, 16'h0000);
        send_cmd(CMD_INSERT, '0, 16'h1234);            // duplicate
        send_cmd(CMD_FIND,   '0, 16'hFFFF);
        send_cmd(CMD_FIND,   '1, '0);
        send_cmd(CMD_ERASE,  '0, '0);
        send_cmd(CMD_FIND,   '0, '0);
        send_cmd(CMD_CLEAR,  '1, '1);
        send_cmd(CMD_FIND,   '1, '0);                  // gone after clear
        // Keys that collide on the home slot (multiples of 2^24 all fold to slot 0);
        // then erase the head to force backward shifts.
        for (int i = 0; i < 6; i++)
            send_cmd(CMD_INSERT, KEY_W'(i << 24), HANDLE_W'(16'hA500 + i));
        send_cmd(CMD_ERASE, KEY_W'(0), '0);
        send_cmd(CMD_FIND,  KEY_W'(5 << 24), '0);
        send_cmd(CMD_ERASE, KEY_W'(2 << 24), '0);
        send_cmd(CMD_FIND,  KEY_W'(4 << 24), '0);
        send_cmd(CMD_CLEAR, '0, '0);

        // Random: mixed traffic, with an insert flood around the middle meant to drive the table to full
        for (int n = 0; n < 600; n += burst) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst; b++) begin
                case ($urandom_range(0, 99)) inside
                    [0:44]:  c = CMD_INSERT;
                    [45:69]: c = CMD_FIND;
                    [70:97]: c = CMD_ERASE;
                    default: c = CMD_CLEAR;
                endcase
                // Around the middle, flood inserts to reach the full limit
                if (n >= 250 && n < 420 && $urandom_range(0, 3) != 0) c = CMD_INSERT;
                send_cmd(c, pick_key(), HANDLE_W'($urandom()));
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
        end
        req_if.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

>>> linear_probe_hash_table.f
design/lpht_pkg.sv
design/lpht_if.sv
design/linear_probe_hash_table.sv
design/lpht_chk.sv
verif/lpht_checker.sv
verif/tb_linear_probe_hash_table.sv
